// File: rtl/lkbg_pkg.sv
// Package for the LCG key byte generator: generator mode codes, LCG constants
// and the modulo-255 reduction that several modes share.
// No dependencies.
package lkbg_pkg;

  // Generator mode codes as written to the mode register. Code 7 is unused
  // and runs the pre-advancing folded generator of code 0.
  typedef enum logic [2:0] {
    MODE_PRE_FOLD = 3'd0,
    MODE_RECIPES  = 3'd1,
    MODE_MASK_LOW = 3'd2,
    MODE_MASK_MID = 3'd3,
    MODE_PASCAL   = 3'd4,
    MODE_RAND_R   = 3'd5,
    MODE_MID_BYTE = 3'd6
  } gen_mode_e;

  localparam logic [31:0] MulPreFold = 32'd22695477;
  localparam logic [31:0] AddPreFold = 32'd1;
  localparam logic [31:0] MulRecipes = 32'd1664525;
  localparam logic [31:0] AddRecipes = 32'd1013904223;
  localparam logic [31:0] MulAnsi    = 32'd1103515245;
  localparam logic [31:0] AddAnsi    = 32'd12345;
  localparam logic [31:0] MulPascal  = 32'd134775813;
  localparam logic [31:0] AddPascal  = 32'd1;
  localparam logic [31:0] MulMidByte = 32'd214013;
  localparam logic [31:0] AddMidByte = 32'd2531011;

  localparam logic [31:0] AllOnes    = 32'hFFFF_FFFF;
  localparam logic [31:0] Mask31     = 32'h7FFF_FFFF;

  // Number of generator steps for one byte in the three-step mode.
  localparam logic [1:0]  RandRSteps = 2'd3;

  // Since 256 is 1 modulo 255, the byte sum keeps the residue; two folds and
  // one conditional subtract finish the reduction.
  function automatic logic [7:0] mod255(input logic [31:0] v);
    logic [9:0] sum;
    logic [8:0] fold;
    sum  = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[31:24]);
    fold = 9'(sum[7:0]) + 9'(sum[9:8]);
    if (fold >= 9'd255) begin
      fold = fold - 9'd255;
    end
    return fold[7:0];
  endfunction

endpackage

// File: rtl/lcg_key_byte_generator.sv
// Top level of the LCG key byte generator: sequencer, shared multiply-add
// unit, modulo-255 reduction and output word register.
// Depends on lkbg_pkg.
//
// Usage: write the generator mode on the configuration channel (cfg_valid_i,
// cfg_ready_o, cfg_generator_mode_i) while the block is idle; cfg_ready_o is
// always high. An input word (seed_i, key_length_i) is accepted on in_valid_i
// and in_ready_o. It produces key_length_i output words, saturated to
// MAX_KEY_BYTES and to 16, each carrying key_byte_o, byte_index_o and
// last_byte_o on out_valid_o and out_ready_i. A length of zero produces none.
//
// Sequencing: every generator step uses the one shared 32x32 multiply-add
// unit, and each byte then passes through the output stage. The rand_r mode
// runs three steps per byte; mode 0 adds one pre-advance step per key.
// in_ready_o is high only while the sequencer is idle, so a new key is only
// taken once the last word of the current key has been computed. When the
// receiver stalls, the sequencer computes the next byte and then holds in
// the output stage until the waiting word is taken, so no word is lost or
// repeated.
//
// Reset clears the sequencer, the output valid flag and the mode register
// (mode 0). The block is ready for an input word in the first cycle after
// reset is released.
module lcg_key_byte_generator #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_generator_mode_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] seed_i,
  input  logic [4:0]  key_length_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  key_byte_o,
  output logic [3:0]  byte_index_o,
  output logic        last_byte_o
);
  import lkbg_pkg::*;

  // Keys never exceed 16 bytes, the reach of the 4-bit byte index.
  localparam int unsigned LenCap  = (MAX_KEY_BYTES < 16) ? MAX_KEY_BYTES : 16;
  localparam logic [4:0]  LenCapW = 5'(LenCap);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_EMIT
  } state_e;

  state_e      state_q, state_d;
  gen_mode_e   mode_q, mode_d;
  logic [31:0] seed_q, seed_d;     // running generator value
  logic [30:0] rnd_q, rnd_d;       // value assembled over three steps
  logic [1:0]  steps_q, steps_d;   // steps still to run for this byte
  logic [4:0]  len_q, len_d;
  logic [3:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic [3:0]  oidx_q, oidx_d;
  logic        olast_q, olast_d;

  logic [31:0] mul_c, add_c;
  logic [31:0] lcg_raw;
  logic [31:0] lcg_next;
  logic [4:0]  len_sat;
  logic [7:0]  byte_val;
  logic        is_last;
  logic        out_free;
  logic [1:0]  byte_steps;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign key_byte_o   = byte_q;
  assign byte_index_o = oidx_q;
  assign last_byte_o  = olast_q;

  assign len_sat    = (key_length_i > LenCapW) ? LenCapW : key_length_i;
  assign is_last    = ((5'(idx_q) + 5'd1) == len_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign byte_steps = (mode_q == MODE_RAND_R) ? RandRSteps : 2'd1;

  // Constants of the generator in use.
  always_comb begin
    case (mode_q)
      MODE_RECIPES: begin
        mul_c = MulRecipes;
        add_c = AddRecipes;
      end
      MODE_MASK_LOW, MODE_MASK_MID, MODE_RAND_R: begin
        mul_c = MulAnsi;
        add_c = AddAnsi;
      end
      MODE_PASCAL: begin
        mul_c = MulPascal;
        add_c = AddPascal;
      end
      MODE_MID_BYTE: begin
        mul_c = MulMidByte;
        add_c = AddMidByte;
      end
      default: begin
        mul_c = MulPreFold;
        add_c = AddPreFold;
      end
    endcase
  end

  // The shared unit: one multiply-add modulo 2^32, then the per-mode fix-up.
  assign lcg_raw = seed_q * mul_c + add_c;

  always_comb begin
    case (mode_q)
      MODE_MASK_LOW, MODE_MASK_MID: lcg_next = lcg_raw & Mask31;
      MODE_RAND_R, MODE_MID_BYTE:   lcg_next = lcg_raw;
      default:                      lcg_next = (lcg_raw == AllOnes) ? 32'd0 : lcg_raw;
    endcase
  end

  // The byte drawn from the generator value after the last step.
  always_comb begin
    case (mode_q)
      MODE_RECIPES, MODE_PASCAL:    byte_val = mod255(seed_q);
      MODE_MASK_LOW:                byte_val = seed_q[7:0];
      MODE_MASK_MID, MODE_MID_BYTE: byte_val = seed_q[23:16];
      MODE_RAND_R:                  byte_val = mod255({1'b0, rnd_q});
      default:                      byte_val = mod255({17'd0, seed_q[30:16]});
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    seed_d      = seed_q;
    rnd_d       = rnd_q;
    steps_d     = steps_q;
    len_d       = len_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    oidx_d      = oidx_q;
    olast_d     = olast_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      mode_d = gen_mode_e'(cfg_generator_mode_i);
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          seed_d = seed_i;
          len_d  = len_sat;
          idx_d  = 4'd0;
          // Mode 0 and the unused code advance once before the first byte.
          if (mode_q == MODE_RAND_R) begin
            steps_d = RandRSteps;
          end else if (mode_q == MODE_PRE_FOLD || mode_q > MODE_MID_BYTE) begin
            steps_d = 2'd2;
          end else begin
            steps_d = 2'd1;
          end
          if (len_sat != 5'd0) begin
            state_d = S_STEP;
          end
        end
      end
      S_STEP: begin
        seed_d = lcg_next;
        if (steps_q == RandRSteps) begin
          rnd_d = {20'd0, lcg_next[26:16]};
        end else begin
          rnd_d = {rnd_q[20:0], 10'd0} ^ {21'd0, lcg_next[25:16]};
        end
        steps_d = steps_q - 2'd1;
        if (steps_q == 2'd1) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          byte_d      = byte_val;
          oidx_d      = idx_q;
          olast_d     = is_last;
          idx_d       = idx_q + 4'd1;
          steps_d     = byte_steps;
          state_d     = is_last ? S_IDLE : S_STEP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_PRE_FOLD;
      steps_q     <= 2'd0;
      len_q       <= 5'd0;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      steps_q     <= steps_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q  <= seed_d;
    rnd_q   <= rnd_d;
    byte_q  <= byte_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
  end

  // An accepted key of nonzero length always starts with a generator step.
  a_start_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && len_sat != 5'd0) |=> (state_q == S_STEP))
    else $error("accepted key did not start stepping");

  // The step counter never runs out while stepping.
  a_steps_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (steps_q != 2'd0))
    else $error("step counter empty in step state");

  // The output stage only works on byte positions inside the key.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (5'(idx_q) < len_q))
    else $error("byte index beyond key length");

  // The final word of a key is followed by a return to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && is_last) |=> (state_q == S_IDLE && out_valid_q))
    else $error("final word did not end the key");

endmodule
